// ===== rtl/svdag_pkg.sv =====
// Shared constants, types and helpers for the voxel DAG point lookup.
`default_nettype none

package svdag_pkg;

    // Storage and walk sizing
    localparam int ADDR_BITS  = 16;
    localparam int COORD_BITS = 16;
    localparam int MAX_LEVELS = 16;

    // Fixed field widths of the request and response items
    localparam int KIND_W     = 1;
    localparam int WADDR_W    = 16;
    localparam int WORD_W     = 32;
    localparam int POINT_W    = 16;
    localparam int LVL_W      = 5;
    localparam int NODE_IDX_W = 16;
    localparam int MASK_W     = 8;
    localparam int OCT_W      = 3;
    localparam int POP_W      = 4;

    localparam int MEM_DEPTH = 2 ** ADDR_BITS;
    localparam int STEP_W    = (MAX_LEVELS > 2) ? $clog2(MAX_LEVELS) : 1;
    localparam int CMP_W     = ((STEP_W > LVL_W) ? STEP_W : LVL_W) + 2;

    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    localparam logic [LVL_W-1:0] TREE_LEVELS_RST = LVL_W'(1);
    localparam logic [LVL_W-1:0] MIN_QUERY_LEVEL = LVL_W'(2);

    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [STEP_W-1:0]     t_step;
    typedef logic [CMP_W-1:0]      t_cmp;

    localparam t_coord CENTER_ROOT = t_coord'(1) << (COORD_BITS - 1);
    localparam t_coord HALF_ROOT   = t_coord'(1) << (COORD_BITS - 2);

    // Controller to datapath
    typedef struct packed {
        logic wr_word;
        logic load_query;
        logic eval;
        logic take_ptr;
        logic set_hit;
        logic publish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic short_query;
        logic fail;
        logic last;
    } t_dp_sts;

    function automatic logic [POP_W-1:0] popcount8(input logic [MASK_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < MASK_W; k++) begin
            n = n + POP_W'(v[k]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/svdag_if.sv =====
// Request and response channel interfaces of the voxel DAG point lookup.
`default_nettype none

interface svdag_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  kind;
    logic [15:0] word_address;
    logic [31:0] word_value;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] point_z;
    logic [4:0]  query_level;

    modport source (
        output valid, kind, word_address, word_value, point_x, point_y, point_z,
               query_level,
        input  ready
    );
    modport sink (
        input  valid, kind, word_address, word_value, point_x, point_y, point_z,
               query_level,
        output ready
    );
endinterface

interface svdag_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] node_index;

    modport source (output valid, found, node_index, input ready);
    modport sink   (input valid, found, node_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/svdag_point_lookup.sv =====
// Top level of the sparse voxel DAG point lookup.
//
// Requests arrive on i_req (valid/ready). kind 0 stores word_value at
// word_address in the node memory and gives no response. kind 1 is a
// point query: it gives exactly one response on o_rsp with found and
// node_index (0 when not found).
// A query walks the DAG from the root with two node-memory reads per level:
// one for the child mask, one for the child pointer, on the single read
// port. i_req.ready is high only while no query is in progress.
// The response sits in an output register, so a new request is taken while
// a response still waits; a further finished query holds until o_rsp.ready
// frees that register.
// i_cfg_we/i_cfg_wdata write tree_levels (reset 1). The user must write it
// only while the block is idle; the block itself does not enforce this.
// Synchronous reset clears the controller and response valid; node memory
// content is undefined until written.
`default_nettype none

module svdag_point_lookup
    import svdag_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LVL_W-1:0] i_cfg_wdata,
    svdag_req_if.sink             i_req,
    svdag_rsp_if.source           o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    svdag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_kind  (i_req.kind),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    svdag_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_word_address (i_req.word_address),
        .i_word_value   (i_req.word_value),
        .i_point_x      (i_req.point_x),
        .i_point_y      (i_req.point_y),
        .i_point_z      (i_req.point_z),
        .i_query_level  (i_req.query_level),
        .o_found        (o_rsp.found),
        .o_node_index   (o_rsp.node_index)
    );

endmodule

`default_nettype wire

// ===== rtl/svdag_dp.sv =====
// Datapath: node memory, walk registers, octant/pointer logic and result register.
`default_nettype none

module svdag_dp
    import svdag_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_cfg_we,
    input  wire logic [LVL_W-1:0]      i_cfg_wdata,
    input  wire logic [WADDR_W-1:0]    i_word_address,
    input  wire logic [WORD_W-1:0]     i_word_value,
    input  wire logic [POINT_W-1:0]    i_point_x,
    input  wire logic [POINT_W-1:0]    i_point_y,
    input  wire logic [POINT_W-1:0]    i_point_z,
    input  wire logic [LVL_W-1:0]      i_query_level,
    output logic                       o_found,
    output logic [NODE_IDX_W-1:0]      o_node_index
);

    logic [WORD_W-1:0] r_mem [MEM_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    logic [LVL_W-1:0] r_tree_levels;
    logic [LVL_W-1:0] r_level;
    t_coord           r_px, r_py, r_pz;
    t_coord           r_cx, r_cy, r_cz;
    t_addr            r_node;
    t_step            r_step;
    logic             r_hit;
    logic             r_out_found;
    logic [NODE_IDX_W-1:0] r_out_node;

    logic              gx, gy, gz;
    logic [OCT_W-1:0]  oct;
    logic [MASK_W-1:0] mask_sh;
    t_coord            half;
    t_addr             ptr_addr;
    t_addr             rd_addr;
    t_cmp              step_next;

    assign gx       = r_px > r_cx;
    assign gy       = r_py > r_cy;
    assign gz       = r_pz > r_cz;
    assign oct      = {gx, gy, gz};
    assign mask_sh  = r_rdata[MASK_W-1:0] >> oct;
    assign half     = HALF_ROOT >> r_step;
    assign ptr_addr = r_node + t_addr'(popcount8(mask_sh));
    assign step_next = t_cmp'(r_step) + t_cmp'(1);

    assign o_sts.short_query = i_query_level < MIN_QUERY_LEVEL;
    assign o_sts.fail = !mask_sh[0]
                     || (step_next >= t_cmp'(r_tree_levels))
                     || (step_next >= t_cmp'(MAX_LEVELS));
    assign o_sts.last = (t_cmp'(r_step) + t_cmp'(2)) == t_cmp'(r_level);

    // Pointer word arrives on the cycle after eval; it is also the next mask address
    always_comb begin
        if (i_cmd.take_ptr) begin
            rd_addr = t_addr'(r_rdata);
        end else if (i_cmd.eval) begin
            rd_addr = ptr_addr;
        end else begin
            rd_addr = r_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_word) begin
            r_mem[t_addr'(i_word_address)] <= i_word_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_levels <= TREE_LEVELS_RST;
        end else if (i_cfg_we) begin
            r_tree_levels <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
            r_step <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (i_cmd.load_query) begin
                r_node <= '0;
                r_step <= '0;
                r_cx   <= CENTER_ROOT;
                r_cy   <= CENTER_ROOT;
                r_cz   <= CENTER_ROOT;
                r_hit  <= 1'b0;
            end
            if (i_cmd.eval) begin
                r_cx <= gx ? r_cx + half : r_cx - half;
                r_cy <= gy ? r_cy + half : r_cy - half;
                r_cz <= gz ? r_cz + half : r_cz - half;
            end
            if (i_cmd.take_ptr) begin
                r_node <= t_addr'(r_rdata);
                r_step <= r_step + t_step'(1);
            end
            if (i_cmd.set_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_px    <= t_coord'(i_point_x);
            r_py    <= t_coord'(i_point_y);
            r_pz    <= t_coord'(i_point_z);
            r_level <= i_query_level;
        end
        if (i_cmd.publish) begin
            r_out_found <= r_hit;
            r_out_node  <= r_hit ? NODE_IDX_W'(r_node) : '0;
        end
    end

    assign o_found      = r_out_found;
    assign o_node_index = r_out_node;

endmodule

`default_nettype wire

// ===== rtl/svdag_ctrl.sv =====
// Controller: request sequencing, per-level walk steps and response valid.
`default_nettype none

module svdag_ctrl
    import svdag_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire logic [KIND_W-1:0] i_req_kind,
    output logic                   o_req_ready,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    input  wire t_dp_sts           i_sts,
    output t_dp_cmd                o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_PTR  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_rsp_valid, n_rsp_valid;
    logic       req_acc;
    logic       slot_free;

    assign o_req_ready = r_state == S_IDLE;
    assign req_acc     = i_req_valid && o_req_ready;
    assign slot_free   = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req_kind == KIND_WRITE) begin
                        o_cmd.wr_word = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_state = i_sts.short_query ? S_DONE : S_READ;
                    end
                end
            end
            S_READ: begin
                // root mask read from the node register
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.fail) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state = S_PTR;
                end
            end
            S_PTR: begin
                o_cmd.take_ptr = 1'b1;
                if (i_sts.last) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/svdag_checker.sv =====
// Port-level checks of the point lookup, bound to the top level.
`default_nettype none

module svdag_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        req_kind,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        rsp_found,
    input wire logic [15:0] rsp_node_index
);

    // Response must hold until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_found |-> rsp_node_index == 16'd0)
        else $error("not-found response with nonzero node index");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp_valid)
        else $error("response valid after reset");

    // A memory write request never produces a response
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready && !req_kind && !rsp_valid |=> !rsp_valid)
        else $error("response after a write request");

    // A query blocks further requests while it walks
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready && req_kind |=> !req_ready)
        else $error("request taken during a query");

endmodule

bind svdag_point_lookup svdag_checker u_svdag_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .req_valid      (i_req.valid),
    .req_ready      (i_req.ready),
    .req_kind       (i_req.kind),
    .rsp_valid      (o_rsp.valid),
    .rsp_ready      (o_rsp.ready),
    .rsp_found      (o_rsp.found),
    .rsp_node_index (o_rsp.node_index)
);

`default_nettype wire

// ===== tb/sv/svdag_lookup_tb_pkg.sv =====
// Request/result types and the expected-result scoreboard for the voxel DAG point lookup bench.
package svdag_lookup_tb_pkg;

    import svdag_pkg::*;

    // Deepest level that the 5-bit request field can carry
    localparam int ANY_LEVEL = (1 << LVL_W) - 1;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [WADDR_W-1:0] word_address;
        logic [WORD_W-1:0]  word_value;
        t_coord             point_x;
        t_coord             point_y;
        t_coord             point_z;
        logic [LVL_W-1:0]   query_level;
    } t_dag_request;

    typedef struct {
        logic                  found;
        logic [NODE_IDX_W-1:0] node_index;
    } t_lookup_result;

    class lookup_scoreboard;
        logic [WORD_W-1:0] node_words [bit [ADDR_BITS-1:0]];
        logic [LVL_W-1:0]  tree_levels;
        t_lookup_result    expected_lookups [$];
        int                errors;
        int                writes;
        int                queries;
        int                hits;
        int                deepest_hit;

        function new();
            tree_levels = TREE_LEVELS_RST;
            errors      = 0;
            writes      = 0;
            queries     = 0;
            hits        = 0;
            deepest_hit = 0;
        endfunction

        function void set_tree_levels(logic [LVL_W-1:0] v);
            tree_levels = v;
        endfunction

        function int pending_count();
            return expected_lookups.size();
        endfunction

        // Walks the DAG for one point. Returns the highest level that reads only
        // written words (ANY_LEVEL when the walk ends on its own).
        function int trace_point(t_coord px, t_coord py, t_coord pz, int level,
                                 output t_lookup_result res);
            t_addr             node;
            t_addr             ptr_addr;
            t_coord            cx, cy, cz, hs;
            logic              gx, gy, gz;
            logic [OCT_W-1:0]  octant;
            logic [MASK_W-1:0] mask;
            int                offset;
            res.found      = 1'b0;
            res.node_index = '0;
            node = '0;
            cx   = CENTER_ROOT;
            cy   = CENTER_ROOT;
            cz   = CENTER_ROOT;
            for (int i = 0; i + 1 < level; i++) begin
                if (!node_words.exists(node))
                    return i + 1;
                mask   = node_words[node][MASK_W-1:0];
                gx     = px > cx;
                gy     = py > cy;
                gz     = pz > cz;
                octant = {gx, gy, gz};
                if (!mask[octant])
                    return ANY_LEVEL;
                if (i + 1 >= tree_levels || i + 1 >= MAX_LEVELS)
                    return ANY_LEVEL;
                hs = (i + 2 > COORD_BITS) ? '0 : t_coord'(1) << (COORD_BITS - i - 2);
                cx = gx ? cx + hs : cx - hs;
                cy = gy ? cy + hs : cy - hs;
                cz = gz ? cz + hs : cz - hs;
                // pointers run from mask bit 7 down, so count set bits at and above the octant
                offset = 0;
                for (int k = int'(octant); k < MASK_W; k++)
                    offset += int'(mask[k]);
                ptr_addr = node + t_addr'(offset);
                if (!node_words.exists(ptr_addr))
                    return i + 1;
                node = node_words[ptr_addr][ADDR_BITS-1:0];
                if (i + 2 == level) begin
                    res.found      = 1'b1;
                    res.node_index = node;
                    return ANY_LEVEL;
                end
            end
            return ANY_LEVEL;
        endfunction

        function void note_request(t_dag_request r);
            t_lookup_result res;
            int             unused_limit;
            if (r.kind == KIND_WRITE) begin
                node_words[r.word_address] = r.word_value;
                writes++;
            end else begin
                unused_limit = trace_point(r.point_x, r.point_y, r.point_z,
                                           int'(r.query_level), res);
                expected_lookups = {expected_lookups, res};
                queries++;
                if (res.found) begin
                    hits++;
                    if (int'(r.query_level) > deepest_hit)
                        deepest_hit = int'(r.query_level);
                end
            end
        endfunction

        function void check_response(logic found, logic [NODE_IDX_W-1:0] node_index);
            t_lookup_result want;
            if (expected_lookups.size() == 0) begin
                $display("%0t: response with no query outstanding: found=%0b node_index=%h",
                         $time, found, node_index);
                errors++;
                return;
            end
            want = expected_lookups.pop_front();
            if (found !== want.found) begin
                $display("%0t: found mismatch: expected %0b, actual %0b",
                         $time, want.found, found);
                errors++;
            end
            if (node_index !== want.node_index) begin
                $display("%0t: node_index mismatch: expected %h, actual %h",
                         $time, want.node_index, node_index);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level bench for the voxel DAG point lookup: directed and random requests against a scoreboard.
module tb_top;

    import svdag_pkg::*;
    import svdag_lookup_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 2 * MAX_LEVELS + 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int N_PHASES        = 6;

    localparam int PHASE_LEVELS     [N_PHASES] = '{16, 1, 5, 31, 0, 15};
    localparam int PHASE_DEPTH      [N_PHASES] = '{16, 3, 6, 16, 2, 12};
    localparam int PHASE_SEND_IDLE  [N_PHASES] = '{0, 81, 0, 19, 0, 81};
    localparam int PHASE_RECV_STALL [N_PHASES] = '{0, 0, 81, 19, 0, 81};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LVL_W-1:0] i_cfg_wdata;

    svdag_req_if req_if ();
    svdag_rsp_if rsp_if ();

    svdag_point_lookup i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    lookup_scoreboard sb = new();
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    int               cycle_count   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d responses outstanding",
                     cycle_count, sb.pending_count());
            $display("tb_top failed");
            $finish;
        end
    end

    // Response side: check on each handshake, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.found, rsp_if.node_index);
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic t_coord rand_coord();
        t_coord v;
        v = t_coord'($urandom);
        // a quarter land on cube centres, where the strict compare matters
        if ($urandom_range(0, 3) == 0)
            v &= ~((t_coord'(1) << $urandom_range(0, COORD_BITS - 1)) - t_coord'(1));
        return v;
    endfunction

    task automatic send_request(input t_dag_request r);
        bit lowered;
        req_if.valid        <= 1'b1;
        req_if.kind         <= r.kind;
        req_if.word_address <= r.word_address;
        req_if.word_value   <= r.word_value;
        req_if.point_x      <= r.point_x;
        req_if.point_y      <= r.point_y;
        req_if.point_z      <= r.point_z;
        req_if.query_level  <= r.query_level;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        lowered = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            if (!lowered)
                req_if.valid <= 1'b0;
            lowered = 1'b1;
            @(posedge i_clk);
        end
    endtask

    task automatic send_write(input t_addr addr, input logic [WORD_W-1:0] value);
        t_dag_request r;
        r.kind         = KIND_WRITE;
        r.word_address = addr;
        r.word_value   = value;
        r.point_x      = t_coord'($urandom);
        r.point_y      = t_coord'($urandom);
        r.point_z      = t_coord'($urandom);
        r.query_level  = LVL_W'($urandom);
        send_request(r);
    endtask

    // Level is pulled down if the walk would touch a word never written
    task automatic send_query(input t_coord x, input t_coord y, input t_coord z,
                              input int level);
        t_dag_request   r;
        t_lookup_result probe;
        int             limit;
        limit = sb.trace_point(x, y, z, ANY_LEVEL, probe);
        if (level > limit)
            level = $urandom_range(0, limit);
        r.kind         = KIND_QUERY;
        r.word_address = WADDR_W'($urandom);
        r.word_value   = WORD_W'($urandom);
        r.point_x      = x;
        r.point_y      = y;
        r.point_z      = z;
        r.query_level  = LVL_W'(level);
        send_request(r);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tree_levels(input logic [LVL_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_tree_levels(v);
        i_cfg_we    <= 1'b0;
    endtask

    // Random DAG: one or two nodes per level, children shared across parents
    task automatic build_dag(input int depth_n);
        t_addr             node_at [MAX_LEVELS][2];
        logic [MASK_W-1:0] mask_of [MAX_LEVELS][2];
        int                width_of [MAX_LEVELS];
        t_addr             next_free;
        t_addr             child;
        int                slot;
        next_free = t_addr'($urandom_range(16'h0100, 16'hF000));
        for (int lvl = 0; lvl < depth_n; lvl++) begin
            width_of[lvl] = (lvl == 0) ? 1 : $urandom_range(1, 2);
            for (int n = 0; n < width_of[lvl]; n++) begin
                mask_of[lvl][n] = ($urandom_range(0, 1) != 0) ? 8'hFF :
                                  MASK_W'($urandom | $urandom);
                if (lvl == 0) begin
                    node_at[lvl][n] = '0;
                end else begin
                    node_at[lvl][n] = next_free;
                    next_free += t_addr'(1);
                    if (lvl < depth_n - 1)
                        next_free += t_addr'($countones(mask_of[lvl][n]));
                end
            end
        end
        for (int lvl = 0; lvl < depth_n; lvl++) begin
            for (int n = 0; n < width_of[lvl]; n++) begin
                send_write(node_at[lvl][n],
                           (WORD_W'($urandom) << MASK_W) | WORD_W'(mask_of[lvl][n]));
                if (lvl < depth_n - 1) begin
                    slot = 1;
                    for (int b = MASK_W - 1; b >= 0; b--) begin
                        if (mask_of[lvl][n][b]) begin
                            child = node_at[lvl+1][$urandom_range(0, width_of[lvl+1] - 1)];
                            send_write(node_at[lvl][n] + t_addr'(slot),
                                       (WORD_W'($urandom) << ADDR_BITS) | WORD_W'(child));
                            slot++;
                        end
                    end
                end
            end
        end
    endtask

    task automatic run_directed();
        // short queries need no memory at all
        send_query(16'h0000, 16'h0000, 16'h0000, 0);
        send_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        // root with octants 7 and 0; junk above the mask
        send_write(16'h0000, 32'hDEAD_0081);
        // reset depth of one allows no descent
        send_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
        wait_idle();
        write_tree_levels(LVL_W'(16));
        send_write(16'h0001, 32'hFFFF_FFFF);
        send_write(16'h0002, 32'h0000_0010);
        // node at the top address: its pointer wraps onto the root word
        send_write(16'hFFFF, 32'h0000_0001);
        send_write(16'h0081, 32'h0000_0000);
        send_write(16'h0010, 32'h5A5A_A518);
        send_write(16'h0011, 32'h1234_0081);
        send_write(16'h0012, 32'h8765_0010);
        send_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
        send_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 3);
        send_query(16'h8000, 16'h8000, 16'h8000, 2);
        send_query(16'h8000, 16'h8000, 16'h8000, 3);
        send_query(16'h5000, 16'h3000, 16'h3000, 3);
        send_query(16'h5000, 16'h3000, 16'h3000, 4);
        send_query(16'h5000, 16'h5000, 16'h3000, 3);
        send_query(16'h3000, 16'h5000, 16'h5000, 4);
        send_query(16'h3000, 16'h5000, 16'h5000, 16);
        send_query(16'h9000, 16'h9000, 16'h9000, 3);
        send_query(16'h9000, 16'h9000, 16'h9000, ANY_LEVEL);
        send_query(16'h0000, 16'h0000, 16'h0000, 16);
    endtask

    task automatic run_phase(input int p);
        int roll;
        wait_idle();
        send_idle_pct = PHASE_SEND_IDLE[p];
        stall_pct     = PHASE_RECV_STALL[p];
        write_tree_levels(LVL_W'(PHASE_LEVELS[p]));
        build_dag(PHASE_DEPTH[p]);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                send_write(t_addr'($urandom), WORD_W'($urandom));
            else if (roll < 16)
                send_query(rand_coord(), rand_coord(), rand_coord(),
                           $urandom_range(0, ANY_LEVEL));
            else
                send_query(rand_coord(), rand_coord(), rand_coord(),
                           $urandom_range(2, PHASE_DEPTH[p] + 1));
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        req_if.valid        <= 1'b0;
        req_if.kind         <= KIND_WRITE;
        req_if.word_address <= '0;
        req_if.word_value   <= '0;
        req_if.point_x      <= '0;
        req_if.point_y      <= '0;
        req_if.point_z      <= '0;
        req_if.query_level  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int p = 0; p < N_PHASES; p++)
            run_phase(p);
        wait_idle();

        $display("Covered %0d memory writes and %0d point queries across %0d depth settings,",
                 sb.writes, sb.queries, N_PHASES + 2);
        $display("with sender gaps and response stalls; %0d hits, deepest at level %0d.",
                 sb.hits, sb.deepest_hit);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
